// ===== hdl/mpdot_pkg.sv =====
// Package for the four-row mixed precision dot unit.
// Item and result types, precision codes, lane control. No dependencies.
package mpdot_pkg;

    localparam int ROWS      = 4;
    localparam int VEC_ELEMS = 4;
    localparam int PROD_W    = 18;

    typedef enum logic [1:0] {
        PREC_INT8 = 2'd0,
        PREC_INT4 = 2'd1,
        PREC_INT2 = 2'd2
    } t_prec;

    typedef struct packed {
        logic signed [7:0] weight_byte_row0;
        logic signed [7:0] weight_byte_row1;
        logic signed [7:0] weight_byte_row2;
        logic signed [7:0] weight_byte_row3;
        logic signed [7:0] vec_elem0;
        logic signed [7:0] vec_elem1;
        logic signed [7:0] vec_elem2;
        logic signed [7:0] vec_elem3;
        logic              last_item;
    } t_item;

    typedef struct packed {
        logic signed [31:0] sum_row0;
        logic signed [31:0] sum_row1;
        logic signed [31:0] sum_row2;
        logic signed [31:0] sum_row3;
    } t_result;

    typedef logic [VEC_ELEMS-1:0][7:0] t_vec;

    typedef struct packed {
        logic load;  // capture product of the incoming item
        logic step;  // add held product into the accumulator
        logic last;  // held product closes the dot product
    } t_lane_ctl;

endpackage

// ===== hdl/mpdot_lane.sv =====
// One row lane: weight unpacking, product sum register and accumulator.
// Depends on mpdot_pkg.
module mpdot_lane #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mpdot_pkg::t_lane_ctl  i_ctl,
    input  logic [1:0]            i_prec,
    input  logic [7:0]            i_wbyte,
    input  mpdot_pkg::t_vec       i_vec,
    output logic [ACC_WIDTH-1:0]  o_sum
);

    logic signed [7:0]                   w [mpdot_pkg::VEC_ELEMS];
    logic signed [15:0]                  p_el [mpdot_pkg::VEC_ELEMS];
    logic signed [mpdot_pkg::PROD_W-1:0] n_prod;
    logic signed [mpdot_pkg::PROD_W-1:0] r_prod;
    logic [ACC_WIDTH-1:0]                r_acc;
    logic [ACC_WIDTH-1:0]                n_acc;

    always_comb begin
        for (int i = 0; i < mpdot_pkg::VEC_ELEMS; i++) begin
            w[i] = '0;
        end
        unique case (i_prec)
            mpdot_pkg::PREC_INT4: begin
                w[0] = {{4{i_wbyte[3]}}, i_wbyte[3:0]};
                w[1] = {{4{i_wbyte[7]}}, i_wbyte[7:4]};
            end
            mpdot_pkg::PREC_INT2: begin
                w[0] = {{6{i_wbyte[1]}}, i_wbyte[1:0]};
                w[1] = {{6{i_wbyte[3]}}, i_wbyte[3:2]};
                w[2] = {{6{i_wbyte[5]}}, i_wbyte[5:4]};
                w[3] = {{6{i_wbyte[7]}}, i_wbyte[7:6]};
            end
            default: begin
                w[0] = i_wbyte;
            end
        endcase
    end

    always_comb begin
        n_prod = '0;
        for (int i = 0; i < mpdot_pkg::VEC_ELEMS; i++) begin
            p_el[i] = w[i] * $signed(i_vec[i]);
            n_prod  = n_prod + mpdot_pkg::PROD_W'(p_el[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= n_prod;
        end
    end

    assign o_sum = r_acc + ACC_WIDTH'(r_prod);
    assign n_acc = i_ctl.last ? '0 : o_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== hdl/mpdot_out.sv =====
// Result register: loads the merged lane sums as one result item and holds it
// until taken. Depends on mpdot_pkg.
module mpdot_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  mpdot_pkg::t_result i_data,
    input  logic               i_stall,
    output logic               o_valid,
    output mpdot_pkg::t_result o_data
);

    logic               r_valid;
    logic               n_valid;
    mpdot_pkg::t_result r_data;

    assign n_valid = i_load | (r_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/four_row_mixed_precision_dot_unit.sv =====
// Top level of the four-row mixed precision dot unit: four row lanes and
// the result register. Depends on mpdot_pkg, mpdot_lane, mpdot_out.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_item)
//  out     | output    | o_out_valid / i_out_stall   | o_out_data (t_result)
//  cfg     | input     | i_cfg_we                    | i_cfg_wdata (precision)
//
// One item per cycle while o_in_stall is low; a last item's sums go via the result register.
// Lanes register the per-item product sum, then accumulate it.
// Reset clears the accumulators, the precision (int8) and all valid flags.
// o_in_stall rises only when a last item waits on a full, stalled result register.
module four_row_mixed_precision_dot_unit #(
    parameter int ACC_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mpdot_pkg::t_item   i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output mpdot_pkg::t_result o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata
);

    logic [1:0]            r_prec_q;
    logic                  r_p_v;
    logic                  r_p_last;
    logic                  blocked;
    logic                  in_acc;
    mpdot_pkg::t_lane_ctl  lane_ctl;
    mpdot_pkg::t_vec       vec;
    logic [7:0]            wbytes [mpdot_pkg::ROWS];
    logic [ACC_WIDTH-1:0]  sums [mpdot_pkg::ROWS];
    logic [31:0]           sums32 [mpdot_pkg::ROWS];
    mpdot_pkg::t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec_q <= mpdot_pkg::PREC_INT8;
        end else if (i_cfg_we) begin
            r_prec_q <= i_cfg_wdata;
        end
    end

    assign blocked    = r_p_v & r_p_last & o_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~blocked;
    assign o_in_stall = blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_p_last <= 1'b0;
        end else if (!blocked) begin
            r_p_v    <= in_acc;
            r_p_last <= i_in_data.last_item;
        end
    end

    assign lane_ctl.load = in_acc;
    assign lane_ctl.step = r_p_v & ~blocked;
    assign lane_ctl.last = r_p_last;

    assign vec    = {i_in_data.vec_elem3, i_in_data.vec_elem2,
                     i_in_data.vec_elem1, i_in_data.vec_elem0};
    assign wbytes[0] = i_in_data.weight_byte_row0;
    assign wbytes[1] = i_in_data.weight_byte_row1;
    assign wbytes[2] = i_in_data.weight_byte_row2;
    assign wbytes[3] = i_in_data.weight_byte_row3;

    for (genvar g = 0; g < mpdot_pkg::ROWS; g++) begin : g_lane
        mpdot_lane #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_prec  (r_prec_q),
            .i_wbyte (wbytes[g]),
            .i_vec   (vec),
            .o_sum   (sums[g])
        );
        // accumulator zero-extended or cut to the 32-bit result field
        assign sums32[g] = 32'(64'(sums[g]));
    end

    assign result.sum_row0 = sums32[0];
    assign result.sum_row1 = sums32[1];
    assign result.sum_row2 = sums32[2];
    assign result.sum_row3 = sums32[3];

    mpdot_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_p_v & r_p_last & ~blocked),
        .i_data  (result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

// ===== hdl/mpdot_checker.sv =====
// Port-level checks for the four-row mixed precision dot unit, with its bind.
// Depends on mpdot_pkg.
module mpdot_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input mpdot_pkg::t_item   i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input mpdot_pkg::t_result o_out_data,
    input logic               i_out_stall
);

    // a waiting result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // input only backs up behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a taken last item is followed by a valid result
    a_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_item |-> ##2 o_out_valid)
        else $error("no result after last item");

endmodule

bind four_row_mixed_precision_dot_unit mpdot_checker u_mpdot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for four_row_mixed_precision_dot_unit: directed items and random
// dot products, checked against a scoreboard with its own accumulators.
// Depends on mpdot_pkg and the unit's RTL.
module testbench;

    localparam logic [1:0] PREC_SPARE = 2'd3;  // unused code, behaves as int8
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1350;

    class dot_scoreboard;
        logic [1:0]         precision;
        logic [31:0]        acc [mpdot_pkg::ROWS];
        mpdot_pkg::t_result expected_sums [$];
        int                 mismatches;

        function new();
            precision  = mpdot_pkg::PREC_INT8;
            mismatches = 0;
            foreach (acc[r]) acc[r] = '0;
        endfunction

        function int weight_dot(logic [7:0] w, int x [4]);
            logic signed [3:0] nib;
            logic signed [1:0] crumb;
            int s;
            s = 0;
            if (precision == mpdot_pkg::PREC_INT4) begin
                for (int i = 0; i < 2; i++) begin
                    nib = w[4*i +: 4];
                    s += nib * x[i];
                end
            end else if (precision == mpdot_pkg::PREC_INT2) begin
                for (int i = 0; i < 4; i++) begin
                    crumb = w[2*i +: 2];
                    s += crumb * x[i];
                end
            end else begin
                s = $signed(w) * x[0];
            end
            return s;
        endfunction

        function void note_item(mpdot_pkg::t_item item);
            logic [7:0] w [mpdot_pkg::ROWS];
            int x [4];
            mpdot_pkg::t_result sums;
            w = '{item.weight_byte_row0, item.weight_byte_row1,
                  item.weight_byte_row2, item.weight_byte_row3};
            x = '{int'(item.vec_elem0), int'(item.vec_elem1),
                  int'(item.vec_elem2), int'(item.vec_elem3)};
            foreach (acc[r]) acc[r] = acc[r] + 32'(weight_dot(w[r], x));
            if (item.last_item) begin
                sums.sum_row0 = acc[0];
                sums.sum_row1 = acc[1];
                sums.sum_row2 = acc[2];
                sums.sum_row3 = acc[3];
                expected_sums.push_back(sums);
                foreach (acc[r]) acc[r] = '0;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(mpdot_pkg::t_result got);
            mpdot_pkg::t_result want;
            logic [31:0] g [mpdot_pkg::ROWS];
            logic [31:0] e [mpdot_pkg::ROWS];
            if (expected_sums.size() == 0) begin
                report("result with no expected sums waiting");
            end else begin
                want = expected_sums.pop_front();
                g = '{got.sum_row0, got.sum_row1, got.sum_row2, got.sum_row3};
                e = '{want.sum_row0, want.sum_row1, want.sum_row2, want.sum_row3};
                foreach (g[r]) begin
                    if (g[r] !== e[r])
                        report($sformatf("sum_row%0d is %0d, expected %0d",
                                         r, $signed(g[r]), $signed(e[r])));
                end
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    mpdot_pkg::t_item   i_in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    mpdot_pkg::t_result o_out_data;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_wdata = '0;

    dot_scoreboard sb = new();
    bit no_gaps = 1'b0;
    int cycles  = 0;

    four_row_mixed_precision_dot_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !no_gaps && ($urandom_range(99) < 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    function automatic mpdot_pkg::t_item make_item(int w0, int w1, int w2, int w3,
                                                   int x0, int x1, int x2, int x3,
                                                   logic last);
        mpdot_pkg::t_item item;
        item.weight_byte_row0 = 8'(w0);
        item.weight_byte_row1 = 8'(w1);
        item.weight_byte_row2 = 8'(w2);
        item.weight_byte_row3 = 8'(w3);
        item.vec_elem0        = 8'(x0);
        item.vec_elem1        = 8'(x1);
        item.vec_elem2        = 8'(x2);
        item.vec_elem3        = 8'(x3);
        item.last_item        = last;
        return item;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic mpdot_pkg::t_item rand_item(logic last);
        return make_item(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                         rand_byte(), rand_byte(), rand_byte(), rand_byte(), last);
    endfunction

    task automatic send_item(input mpdot_pkg::t_item item);
        while (!no_gaps && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_precision(input logic [1:0] code);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.precision = code;
    endtask

    task automatic run_directed();
        // int8 from reset: extreme products, then a one-item dot product
        send_item(make_item(-128, -128, -128, -128, -128, 127, 127, 127, 1'b0));
        send_item(make_item(127, -128, 0, -1, 127, -128, -128, -128, 1'b1));
        send_item(make_item(127, 127, 127, 127, -128, 0, 0, 0, 1'b1));
        write_precision(mpdot_pkg::PREC_INT4);
        send_item(make_item(8'h88, 8'h77, 8'h87, 8'h78, -128, -128, 127, 127, 1'b0));
        send_item(make_item(8'h88, 8'h77, 8'h87, 8'h78, 127, -128, 0, 0, 1'b1));
        write_precision(mpdot_pkg::PREC_INT2);
        send_item(make_item(8'hAA, 8'h55, 8'hFF, 8'h1B, -128, 127, -1, 1, 1'b0));
        send_item(make_item(8'hAA, 8'h55, 8'hFF, 8'h1B, 127, -128, -128, 127, 1'b1));
        write_precision(PREC_SPARE);
        send_item(make_item(-128, 127, 8'h55, 8'hAA, -128, 127, 127, -128, 1'b1));
        write_precision(mpdot_pkg::PREC_INT8);
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    endtask

    task automatic run_random();
        int sent;
        int groups;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_precision(2'($urandom_range(3)));
            groups = $urandom_range(6, 1);
            repeat (groups) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                               : $urandom_range(12, 1);
                for (int k = 0; k < len; k++) begin
                    no_gaps = (sent >= 500 && sent < 800);
                    send_item(rand_item(k == len - 1));
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        wait_drained();
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== four_row_mixed_precision_dot_unit.f =====
hdl/mpdot_pkg.sv
hdl/mpdot_lane.sv
hdl/mpdot_out.sv
hdl/four_row_mixed_precision_dot_unit.sv
hdl/mpdot_checker.sv
tb/testbench.sv
